// ===== design/substring_find_all_nonoverlap_defines.svh =====
// ----------------------------------------------------------------------------
// substring_find_all_nonoverlap assertion macros
// Concurrent check macros used by the substring search top-level design file
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_FIND_ALL_NONOVERLAP_DEFINES_SVH
`define SUBSTRING_FIND_ALL_NONOVERLAP_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define SFAN_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("sfan: same cycle check failed");
// next-cycle implication
`define SFAN_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("sfan: next cycle check failed");
`else
`define SFAN_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define SFAN_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== design/sfan_pkg.sv =====
// ----------------------------------------------------------------------------
// sfan_pkg
// Types, constants and helpers of the streaming substring search
// ----------------------------------------------------------------------------
package sfan_pkg;

	localparam int PAT_MAX_DEF    = 16;
	localparam int STREAM_MAX_DEF = 65536;
	localparam int OQ_DEPTH       = 4;

	localparam logic KIND_MATCH   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [1:0] REG_PAT_LOW   = 2'd0;
	localparam logic [1:0] REG_PAT_HIGH  = 2'd1;
	localparam logic [1:0] REG_PAT_LEN   = 2'd2;
	localparam logic [1:0] REG_SRCH_STRT = 2'd3;

	localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} req_t;

	typedef struct packed {
		logic        result_kind;
		logic [15:0] match_position;
		logic [16:0] match_count;
		logic        overflow;
		logic        last_result;
	} rsp_t;

	// byte idx of the 128-bit pattern, byte 0 in the low bits
	function automatic logic [7:0] pat_byte(input logic [127:0] pat, input logic [3:0] idx);
		pat_byte = pat[{idx, 3'b000} +: 8];
	endfunction

endpackage

// ===== design/substring_find_all_nonoverlap.sv =====
// results of an accepted request are registered in the result queue and shown on rsp from its head
// throughput: one byte per cycle while req_stall is low; the window compare is a single parallel stage
// a byte that ends the stream on a match queues two results, so a run of such
// bytes is limited by the one-result-a-cycle drain (while rsp_stall is low) of the four-entry result queue
// reset: arst_n clears config registers (pattern length to 1), stream state and queue pointers at once; no init sweep
// ----------------------------------------------------------------------------
// substring_find_all_nonoverlap
// Streaming leftmost non-overlapping search of a 1 to 16 byte pattern
// ----------------------------------------------------------------------------
`include "substring_find_all_nonoverlap_defines.svh"

module substring_find_all_nonoverlap
	import sfan_pkg::*;
#(
	parameter int PAT_MAX    = PAT_MAX_DEF,
	parameter int STREAM_MAX = STREAM_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp_data
);

	localparam int POS_W = $clog2(STREAM_MAX + 1);
	localparam int NAS_W = (POS_W > 16) ? POS_W : 16;
	localparam int VB_W  = $clog2(PAT_MAX + 1);

	// configuration registers
	logic [63:0] pat_low_q;
	logic [63:0] pat_high_q;
	logic [4:0]  pat_len_q;
	logic [15:0] srch_strt_q;

	// stream state
	logic [PAT_MAX-1:0][7:0] win_q;
	logic [VB_W-1:0]         vb_q;
	logic [POS_W-1:0]        pos_q;
	logic [NAS_W-1:0]        nas_q;
	logic [16:0]             cnt_q;
	logic                    ovf_q;

	logic                    cfg_wr;
	logic                    acc;
	logic                    room;
	logic [PAT_MAX-1:0][7:0] win_nxt;
	logic [VB_W-1:0]         vb_nxt;
	logic                    ovf_path;
	logic                    len_ok;
	logic                    win_hit;
	logic                    hit;
	logic [POS_W-1:0]        start;
	logic [NAS_W-1:0]        pos_inc;
	logic [16:0]             cnt_nxt;
	logic                    ovf_nxt;
	logic [1:0]              push_n;
	rsp_t                    match_res;
	rsp_t                    sum_res;
	rsp_t                    item0;
	rsp_t                    item1;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[4:3])
			REG_PAT_LOW:   prdata = pat_low_q;
			REG_PAT_HIGH:  prdata = pat_high_q;
			REG_PAT_LEN:   prdata = {59'b0, pat_len_q};
			REG_SRCH_STRT: prdata = {48'b0, srch_strt_q};
			default:       prdata = '0;
		endcase
	end

	assign req_stall = !room;
	assign acc       = req_valid && !req_stall;

	always_comb begin
		win_nxt[0] = req_data.data_byte;
		for (int k = 1; k < PAT_MAX; k++) begin
			win_nxt[k] = win_q[k-1];
		end
	end

	assign vb_nxt   = (vb_q < VB_W'(PAT_MAX)) ? vb_q + VB_W'(1) : vb_q;
	assign ovf_path = (pos_q >= POS_W'(STREAM_MAX));
	assign len_ok   = (pat_len_q != 5'd0) && (pat_len_q <= 5'(PAT_MAX));
	assign start    = pos_q + POS_W'(1) - POS_W'(pat_len_q);
	assign pos_inc  = NAS_W'(pos_q) + NAS_W'(1);

	sfan_match #(
		.PAT_MAX (PAT_MAX)
	) u_match (
		.win (win_nxt),
		.pat ({pat_high_q, pat_low_q}),
		.len (pat_len_q),
		.hit (win_hit)
	);

	assign hit = !ovf_path && len_ok && (5'(vb_nxt) >= pat_len_q)
		&& (NAS_W'(start) >= nas_q) && win_hit;

	assign cnt_nxt = (hit && cnt_q != COUNT_MAX) ? cnt_q + 17'd1 : cnt_q;
	assign ovf_nxt = ovf_q || ovf_path;

	always_comb begin
		match_res.result_kind    = KIND_MATCH;
		match_res.match_position = 16'(start);
		match_res.match_count    = cnt_nxt;
		match_res.overflow       = ovf_q;
		match_res.last_result    = !req_data.last_byte;

		sum_res.result_kind    = KIND_SUMMARY;
		sum_res.match_position = 16'd0;
		sum_res.match_count    = cnt_nxt;
		sum_res.overflow       = ovf_nxt;
		sum_res.last_result    = 1'b1;

		item0  = hit ? match_res : sum_res;
		item1  = sum_res;
		push_n = acc ? (2'(hit) + 2'(req_data.last_byte)) : 2'd0;
	end

	sfan_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.item0     (item0),
		.item1     (item1),
		.room      (room),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q   <= '0;
			pat_high_q  <= '0;
			pat_len_q   <= 5'd1;
			srch_strt_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				REG_PAT_LOW:   pat_low_q   <= pwdata;
				REG_PAT_HIGH:  pat_high_q  <= pwdata;
				REG_PAT_LEN:   pat_len_q   <= pwdata[4:0];
				REG_SRCH_STRT: srch_strt_q <= pwdata[15:0];
				default:       pat_len_q   <= pat_len_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			vb_q  <= '0;
			pos_q <= '0;
			nas_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cfg_wr && paddr[4:3] == REG_SRCH_STRT) begin
			// new start offset only counts before the first byte of a stream
			if (pos_q == '0 && !ovf_q) begin
				nas_q <= NAS_W'(pwdata[15:0]);
			end
		end else if (acc) begin
			if (req_data.last_byte) begin
				win_q <= '0;
				vb_q  <= '0;
				pos_q <= '0;
				nas_q <= NAS_W'(srch_strt_q);
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (ovf_path) begin
				ovf_q <= 1'b1;
			end else begin
				win_q <= win_nxt;
				vb_q  <= vb_nxt;
				pos_q <= pos_q + POS_W'(1);
				cnt_q <= cnt_nxt;
				// resume just past the accepted match
				if (hit) begin
					nas_q <= pos_inc;
				end
			end
		end
	end

	`SFAN_ASSERT_NXT(a_end_clears, clk, arst_n, acc && req_data.last_byte, pos_q == '0 && cnt_q == '0 && !ovf_q && rsp_valid)
	`SFAN_ASSERT_NXT(a_resume_past, clk, arst_n, acc && hit && !req_data.last_byte, nas_q == $past(pos_inc) && cnt_q != '0)
	`SFAN_ASSERT_IMP(a_ovf_saturated, clk, arst_n, ovf_q, pos_q == POS_W'(STREAM_MAX))
	`SFAN_ASSERT_IMP(a_no_hit_overlong, clk, arst_n, ovf_path, !hit)

endmodule

// ===== design/sfan_match.sv =====
// ----------------------------------------------------------------------------
// sfan_match
// Parallel compare of the byte window against the pattern ending at the newest byte
// ----------------------------------------------------------------------------
module sfan_match
	import sfan_pkg::*;
#(
	parameter int PAT_MAX = PAT_MAX_DEF
) (
	input  logic [PAT_MAX-1:0][7:0] win,
	input  logic [127:0]            pat,
	input  logic [4:0]              len,
	output logic                    hit
);

	always_comb begin
		hit = 1'b1;
		for (int k = 0; k < PAT_MAX; k++) begin
			// window slot k holds pattern byte len-1-k
			if (5'(k) < len) begin
				if (win[k] != pat_byte(pat, 4'(len - 5'd1 - 5'(k)))) begin
					hit = 1'b0;
				end
			end
		end
	end

endmodule

// ===== design/sfan_outq.sv =====
// ----------------------------------------------------------------------------
// sfan_outq
// Small result queue taking up to two results a cycle and giving one while rsp_stall is low
// ----------------------------------------------------------------------------
module sfan_outq
	import sfan_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  rsp_t       item0,
	input  rsp_t       item1,
	output logic       room,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp_data
);

	localparam int PTR_W = $clog2(OQ_DEPTH);

	rsp_t             mem_q [OQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             pop;

	assign rsp_valid = (cnt_q != '0);
	assign rsp_data  = mem_q[rd_ptr_q];
	assign pop       = rsp_valid && !rsp_stall;
	// two free slots needed for a request that ends a stream on a match
	assign room      = (cnt_q <= (PTR_W+1)'(OQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= item0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + (PTR_W+1)'(push_n) - (PTR_W+1)'(pop);
		end
	end

endmodule
